[hdl/conv3x3_border_keep_filter_macros.svh]
// assertion macros shared by the conv3x3 border-keep filter rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef CONV3X3_BORDER_KEEP_FILTER_MACROS_SVH
`define CONV3X3_BORDER_KEEP_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define CVK_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define CVK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CVK_ASSERT_IMPL(label, ante, cons, msg)
`define CVK_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hdl/cvk_pkg.sv]
// shared constants, types and helper functions of the conv3x3 border-keep filter
// no dependencies
`timescale 1ns / 1ps

package cvk_pkg;

    // geometry
    localparam int MAX_WIDTH = 62;
    localparam int MIN_DIM   = 3;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = 6;
    localparam int ROW_W     = 12;

    // data widths
    localparam int PIX_W    = 8;
    localparam int COEF_W   = 8;
    localparam int KROW_W   = 24;
    localparam int RES_W    = 16;
    localparam int PROD_W   = 17;
    localparam int SUM_W    = 20;
    localparam int MAG_W    = 19;

    // divide by nine: floor(m / 9) == (m * DIV_RECIP) >> DIV_SHIFT for m < 2**MAG_W
    localparam int DIV_RECIP_W = 19;
    localparam int DIV_SHIFT   = 22;
    localparam int SCALED_W    = MAG_W + DIV_RECIP_W;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 19'd466034;

    // configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_MID    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [KROW_W-1:0] RST_KERNEL_TOP    = 24'd65801;
    localparam logic [KROW_W-1:0] RST_KERNEL_MID    = 24'd65537;
    localparam logic [KROW_W-1:0] RST_KERNEL_BOTTOM = 24'd3604740;
    localparam logic [COL_W-1:0]  RST_IMAGE_WIDTH   = 6'd6;
    localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT  = 12'd3;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic commit;
        logic mul;
        logic acc;
        logic scale;
        logic fl_clear;
        logic fl_read;
        logic fl_next;
        logic load_main;
        logic load_flush;
    } cvk_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic emit;
        logic last;
        logic fl_final;
        logic out_free;
    } cvk_stat_t;

    // signed coefficient in byte position col of a kernel row
    function automatic logic signed [COEF_W-1:0] kernel_coeff(
        input logic [KROW_W-1:0] row,
        input logic [1:0]        col
    );
        kernel_coeff = row[COEF_W*col +: COEF_W];
    endfunction

endpackage

[hdl/cvk_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cvk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cvk_datapath.sv]
// datapath: position counters, line stores, 3x3 window, multiply/sum/scale and output register
// depends on cvk_pkg, cvk_ram and the assertion macro header
`timescale 1ns / 1ps
`include "conv3x3_border_keep_filter_macros.svh"

module cvk_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cvk_pkg::cvk_cmd_t                 cmd,
    output cvk_pkg::cvk_stat_t                stat,
    input  logic [cvk_pkg::PIX_W-1:0]         pixel,
    input  logic [cvk_pkg::KROW_W-1:0]        kernel_row_top,
    input  logic [cvk_pkg::KROW_W-1:0]        kernel_row_mid,
    input  logic [cvk_pkg::KROW_W-1:0]        kernel_row_bottom,
    input  logic [cvk_pkg::COL_W-1:0]         image_width,
    input  logic [cvk_pkg::ROW_W-1:0]         image_height,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [cvk_pkg::RES_W-1:0]  filtered,
    output logic                              end_of_run,
    output logic                              end_of_image
);
    import cvk_pkg::*;

    // effective geometry
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    // position counters and per-request flags
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              emit_reg, last_reg, interior_reg;
    logic              take_emit, take_last, take_interior;
    logic [ADDR_W-1:0] take_ci, ci_reg;
    logic [PIX_W-1:0]  pix_reg, centre_reg;

    // window and arithmetic
    logic [PIX_W-1:0]    win_reg [3][3];
    logic [PROD_W-1:0]   prod_reg [3][3];
    logic [PROD_W-1:0]   prod_next [3][3];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    mag_full;
    logic [MAG_W-1:0]    mag;
    logic [SCALED_W-1:0] scaled_reg, scaled_next;
    logic                neg_reg;
    logic [RES_W-1:0]    quo_mag, quo_signed;
    logic [KROW_W-1:0]   krow [3];

    // line stores
    logic [PIX_W-1:0]  up_rdata, lo_rdata;
    logic              up_re, lo_re;
    logic [ADDR_W-1:0] up_raddr, lo_raddr;

    // flush and output
    logic [COL_W-1:0] fidx_reg;
    logic             fl_final;
    logic             load;
    logic [RES_W-1:0] main_value, flush_value;
    logic             result_valid_reg;
    logic [RES_W-1:0] filtered_reg;
    logic             end_of_run_reg, end_of_image_reg;

    always_comb
    begin
        if (image_width < COL_W'(MIN_DIM))
        begin
            w_eff = COL_W'(MIN_DIM);
        end
        else if (image_width > COL_W'(MAX_WIDTH))
        begin
            w_eff = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = image_width;
        end
        if (image_height < ROW_W'(MIN_DIM))
        begin
            h_eff = ROW_W'(MIN_DIM);
        end
        else
        begin
            h_eff = image_height;
        end
    end

    assign w_last = w_eff - COL_W'(1);
    assign h_last = h_eff - ROW_W'(1);

    assign take_last     = (col_reg >= w_last) && (row_reg >= h_last);
    assign take_emit     = (row_reg >= ROW_W'(2))
                         || ((row_reg == ROW_W'(1)) && (col_reg >= COL_W'(1)));
    assign take_interior = (col_reg >= COL_W'(2)) && (col_reg <= w_last)
                         && (row_reg >= ROW_W'(2)) && (row_reg <= h_last);
    assign take_ci       = (col_reg < COL_W'(MAX_WIDTH)) ? ADDR_W'(col_reg)
                                                         : ADDR_W'(MAX_WIDTH - 1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take_last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_reg >= w_last)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            emit_reg         <= 1'b0;
            last_reg         <= 1'b0;
            interior_reg     <= 1'b0;
            fidx_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                emit_reg     <= take_emit;
                last_reg     <= take_last;
                interior_reg <= take_interior;
            end
            if (cmd.fl_clear)
            begin
                fidx_reg <= '0;
            end
            else if (cmd.fl_next)
            begin
                fidx_reg <= fidx_reg + COL_W'(1);
            end
            if (load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // line stores: upper takes what the lower held, lower takes the new pixel
    assign up_re    = cmd.take || (cmd.fl_read && (fidx_reg == '0));
    assign lo_re    = cmd.take || (cmd.fl_read && (fidx_reg != '0));
    assign up_raddr = cmd.take ? take_ci : ADDR_W'(w_last);
    assign lo_raddr = cmd.take ? take_ci : ADDR_W'(fidx_reg - COL_W'(1));

    cvk_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ci_reg),
        .wdata (lo_rdata),
        .re    (up_re),
        .raddr (up_raddr),
        .rdata (up_rdata)
    );

    cvk_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_lower (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ci_reg),
        .wdata (pix_reg),
        .re    (lo_re),
        .raddr (lo_raddr),
        .rdata (lo_rdata)
    );

    // flipped kernel: window (i,j) meets coefficient (2-i,2-j)
    assign krow[0] = kernel_row_top;
    assign krow[1] = kernel_row_mid;
    assign krow[2] = kernel_row_bottom;

    always_comb
    begin
        logic signed [COEF_W-1:0] k;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k = kernel_coeff(krow[2-i], 2'(2 - j));
                prod_next[i][j] = {{(PROD_W-COEF_W){k[COEF_W-1]}}, k}
                                * {{(PROD_W-PIX_W){1'b0}}, win_reg[i][j]};
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_next = sum_next
                         + {{(SUM_W-PROD_W){prod_reg[i][j][PROD_W-1]}}, prod_reg[i][j]};
            end
        end
    end

    // magnitude times reciprocal, sign restored after the shift
    assign mag_full    = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
    assign mag         = mag_full[MAG_W-1:0];
    assign scaled_next = {{DIV_RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV_RECIP};
    assign quo_mag     = scaled_reg[DIV_SHIFT +: RES_W];
    assign quo_signed  = neg_reg ? (RES_W'(0) - quo_mag) : quo_mag;

    assign main_value  = interior_reg ? quo_signed
                                      : {{(RES_W-PIX_W){1'b0}}, centre_reg};
    assign flush_value = {{(RES_W-PIX_W){1'b0}}, (fidx_reg == '0) ? up_rdata : lo_rdata};
    assign fl_final    = (fidx_reg == w_eff);
    assign load        = cmd.load_main || cmd.load_flush;

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg    <= pixel;
            ci_reg     <= take_ci;
            centre_reg <= win_reg[1][2];
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_rdata;
            win_reg[1][2] <= lo_rdata;
            win_reg[2][2] <= pix_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.scale)
        begin
            scaled_reg <= scaled_next;
            neg_reg    <= sum_reg[SUM_W-1];
        end
        if (load)
        begin
            filtered_reg     <= cmd.load_main ? main_value : flush_value;
            end_of_run_reg   <= cmd.load_main ? !last_reg : fl_final;
            end_of_image_reg <= cmd.load_main ? 1'b0 : fl_final;
        end
    end

    assign stat.emit     = emit_reg;
    assign stat.last     = last_reg;
    assign stat.fl_final = fl_final;
    assign stat.out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign filtered     = filtered_reg;
    assign end_of_run   = end_of_run_reg;
    assign end_of_image = end_of_image_reg;

    `CVK_ASSERT_IMPL(a_eoi_ends_run, result_valid && end_of_image, end_of_run, "image end not run end")
    `CVK_ASSERT_IMPL(a_ci_in_range, cmd.commit, ci_reg < ADDR_W'(MAX_WIDTH), "line address out of range")
    `CVK_ASSERT_IMPL(a_load_when_free, load, stat.out_free, "held result overwritten")

endmodule

[hdl/cvk_ctrl.sv]
// controller state machine: sequences read, window update, arithmetic, output and flush
// depends on cvk_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "conv3x3_border_keep_filter_macros.svh"

module cvk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  cvk_pkg::cvk_stat_t stat,
    output cvk_pkg::cvk_cmd_t  cmd
);
    import cvk_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_MUL      = 3'd2;
    localparam logic [2:0] S_SUM      = 3'd3;
    localparam logic [2:0] S_SCALE    = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;
    localparam logic [2:0] S_FL_RD    = 3'd6;
    localparam logic [2:0] S_FL_EMIT  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.take     = 1'b1;
                    cmd.fl_clear = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.commit = 1'b1;
                state_next = stat.emit ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.acc    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_main = 1'b1;
                    state_next    = stat.last ? S_FL_RD : S_IDLE;
                end
            end
            S_FL_RD:
            begin
                cmd.fl_read = 1'b1;
                state_next  = S_FL_EMIT;
            end
            S_FL_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_flush = 1'b1;
                    cmd.fl_next    = 1'b1;
                    state_next     = stat.fl_final ? S_IDLE : S_FL_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign pixel_ready = (state_reg == S_IDLE);

    `CVK_ASSERT_NEXT(a_take_then_commit, cmd.take, cmd.commit, "read not followed by commit")
    `CVK_ASSERT_IMPL(a_idle_no_load, pixel_ready, !(cmd.load_main || cmd.load_flush), "load while idle")
    `CVK_ASSERT_NEXT(a_last_starts_flush, cmd.load_main && stat.last, cmd.fl_read, "flush missed")

endmodule

[hdl/conv3x3_border_keep_filter.sv]
// top level of the conv3x3 border-keep filter: apb register file, controller and datapath
// depends on cvk_pkg, cvk_ctrl, cvk_datapath (and through it cvk_ram)
`timescale 1ns / 1ps

// usage
// - pixels enter in raster order on pixel/pixel_valid/pixel_ready, one request each
// - results leave on filtered/end_of_run/end_of_image with result_valid/result_ready
// - the request at raster index k gives the result for index k-W-1; the first W+1
//   requests of an image give nothing, the last one also flushes the final W+1 results
// - interior results are the flipped-kernel sum of products divided by nine,
//   truncated toward zero; border pixels come out unchanged
// - end_of_run marks the last result of a request, end_of_image the last of an image
// - steps with a ready receiver: a request without a result goes through line store read
//   and window update; one with a result goes through line store read, window update,
//   multiply, sum, scale and load; the last request of an image then does a line store
//   read and a load for each flushed value
// - the controller walks one request through the line store read port and the
//   multiply/sum/scale registers before taking another
// - a stalled receiver holds the output register; the block may take the next
//   request but waits in its load step until the held result is taken
// - reset clears counters, handshake state and the registers to their defaults;
//   line stores and window need no clearing and are written before use
// - write configuration only while idle; pready is always high

module conv3x3_border_keep_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel channel
    input  logic [cvk_pkg::PIX_W-1:0]          pixel,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    // result channel
    output logic signed [cvk_pkg::RES_W-1:0]   filtered,
    output logic                               end_of_run,
    output logic                               end_of_image,
    output logic                               result_valid,
    input  logic                               result_ready,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cvk_pkg::PADDR_W-1:0]        paddr,
    input  logic [cvk_pkg::PDATA_W-1:0]        pwdata,
    output logic [cvk_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import cvk_pkg::*;

    logic [KROW_W-1:0]    kernel_top_reg;
    logic [KROW_W-1:0]    kernel_mid_reg;
    logic [KROW_W-1:0]    kernel_bottom_reg;
    logic [COL_W-1:0]     image_width_reg;
    logic [ROW_W-1:0]     image_height_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    cvk_cmd_t             cmd;
    cvk_stat_t            stat;

    // register index is the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg    <= RST_KERNEL_TOP;
            kernel_mid_reg    <= RST_KERNEL_MID;
            kernel_bottom_reg <= RST_KERNEL_BOTTOM;
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_KERNEL_TOP:    kernel_top_reg    <= pwdata[KROW_W-1:0];
                REG_KERNEL_MID:    kernel_mid_reg    <= pwdata[KROW_W-1:0];
                REG_KERNEL_BOTTOM: kernel_bottom_reg <= pwdata[KROW_W-1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[COL_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[ROW_W-1:0];
                default:
                begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (reg_idx)
            REG_KERNEL_TOP:    prdata = PDATA_W'(kernel_top_reg);
            REG_KERNEL_MID:    prdata = PDATA_W'(kernel_mid_reg);
            REG_KERNEL_BOTTOM: prdata = PDATA_W'(kernel_bottom_reg);
            REG_IMAGE_WIDTH:   prdata = PDATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = PDATA_W'(image_height_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencing
    cvk_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // line stores, window, arithmetic and output register
    cvk_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .pixel             (pixel),
        .kernel_row_top    (kernel_top_reg),
        .kernel_row_mid    (kernel_mid_reg),
        .kernel_row_bottom (kernel_bottom_reg),
        .image_width       (image_width_reg),
        .image_height      (image_height_reg),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .filtered          (filtered),
        .end_of_run        (end_of_run),
        .end_of_image      (end_of_image)
    );

endmodule
